// ===== design/alrm_pkg.sv =====
// Shared constants, codes and types of the audio loop recorder and mixer.
package alrm_pkg;

   localparam int LOOP_DEPTH = 262144;
   localparam int ADDR_W     = $clog2(LOOP_DEPTH);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int WORD_W     = 32;
   localparam int SAMPLE_W   = 16;
   localparam int LIVE_LSB   = 2;
   localparam int COUNT_W    = 3;

   localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(LOOP_DEPTH - 1);
   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(LOOP_DEPTH);

   localparam logic [COUNT_W-1:0] CLICK_RESTART   = 3'd1;
   localparam logic [COUNT_W-1:0] CLICK_RESTARTED = 3'd2;
   localparam logic [COUNT_W-1:0] CLICK_FIX_LEN   = 3'd3;
   localparam logic [COUNT_W-1:0] CLICK_LEN_FIXED = 3'd4;
   localparam logic [COUNT_W-1:0] CLICK_MAX       = 3'd7;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_CLICK  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] live;
      logic                rec;
   } loop_op_type;

endpackage

// ===== design/alrm_req_if.sv =====
// Request channel interface carrying clicks and sample words.
interface alrm_req_if;
   import alrm_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [WORD_W-1:0]   sample_word;

   modport source(output valid, req_type, sample_word, input ready);
   modport sink(input valid, req_type, sample_word, output ready);
endinterface

// ===== design/alrm_rsp_if.sv =====
// Response channel interface carrying mixed samples.
interface alrm_rsp_if;
   import alrm_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] mixed_sample;
   logic                recording_active;

   modport source(output valid, mixed_sample, recording_active, input ready);
   modport sink(input valid, mixed_sample, recording_active, output ready);
endinterface

// ===== design/alrm_front.sv =====
// Front end: accepts words, applies the click rules and issues loop operations.
module alrm_front (
   input  logic                clock,
   input  logic                reset,
   alrm_req_if.sink            req_chan,
   input  logic                clear_busy,
   output logic                push_valid,
   input  logic                push_ready,
   output alrm_pkg::loop_op_type push_data
);
   import alrm_pkg::*;

   logic [COUNT_W-1:0] click_count_ff, click_count_in;
   logic               record_ff, record_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;

   logic               accept;
   logic               is_click;
   logic [COUNT_W-1:0] count_a;
   logic [ADDR_W-1:0]  pos_a;
   logic [LEN_W-1:0]   len_a;
   logic [COUNT_W-1:0] count_b;
   logic [LEN_W-1:0]   pos_inc;

   assign is_click       = (req_chan.req_type == REQ_CLICK);
   assign req_chan.ready = !clear_busy && push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = req_chan.valid && !clear_busy && !is_click;

   always_comb begin
      count_a = click_count_ff;
      pos_a   = pos_ff;
      if (click_count_ff == CLICK_RESTART) begin
         count_a = CLICK_RESTARTED;
         pos_a   = '0;
      end
      count_b = count_a;
      len_a   = len_ff;
      if (count_a == CLICK_FIX_LEN) begin
         count_b = CLICK_LEN_FIXED;
         len_a   = {1'b0, pos_a};
      end
      pos_inc = {1'b0, pos_a} + LEN_W'(1);
   end

   assign push_data.addr = pos_a;
   assign push_data.live = req_chan.sample_word[LIVE_LSB +: SAMPLE_W];
   assign push_data.rec  = record_ff;

   always_comb begin
      click_count_in = click_count_ff;
      record_in      = record_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      if (accept) begin
         if (is_click) begin
            if (click_count_ff != CLICK_MAX) begin
               click_count_in = click_count_ff + COUNT_W'(1);
            end
            record_in = !record_ff;
         end else begin
            click_count_in = count_b;
            len_in         = len_a;
            pos_in         = (pos_inc >= len_a) ? '0 : pos_inc[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         click_count_ff <= '0;
         record_ff      <= 1'b0;
         pos_ff         <= '0;
         len_ff         <= LEN_RESET;
      end else begin
         click_count_ff <= click_count_in;
         record_ff      <= record_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
      end
   end

   a_pos_in_loop: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, pos_ff} < len_ff) || (pos_ff == '0)))
      else $error("loop position outside the loop length");

   a_sample_settles_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_click) |=>
         (click_count_ff != CLICK_RESTART) && (click_count_ff != CLICK_FIX_LEN))
      else $error("click rule left pending after a sample");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !accept)
      else $error("word accepted during the store clearing pass");

endmodule

// ===== design/alrm_queue.sv =====
// Two-entry queue of loop operations between the front and back ends.
module alrm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  alrm_pkg::loop_op_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output alrm_pkg::loop_op_type pop_data
);
   import alrm_pkg::*;

   loop_op_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd3))
      else $error("queue count beyond its depth");

endmodule

// ===== design/alrm_back.sv =====
// Back end: clears and accesses the loop store and forms the mixed sample.
module alrm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  alrm_pkg::loop_op_type pop_data,
   output logic                  clear_busy,
   alrm_rsp_if.source            rsp_chan
);
   import alrm_pkg::*;

   logic [SAMPLE_W-1:0] loop_store [LOOP_DEPTH];

   logic                clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]   clear_addr_ff, clear_addr_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-2:0] s1_live_half_ff;
   logic                s1_rec_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_mix_ff;
   logic                out_rec_ff;

   logic                out_free;
   logic                s1_adv;
   logic                pop;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic [SAMPLE_W-1:0] mix;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign pop_ready  = (!s1_valid_ff || out_free) && !clear_busy_ff;
   assign pop        = pop_valid && pop_ready;
   assign clear_busy = clear_busy_ff;

   assign mem_we    = clear_busy_ff || (pop && pop_data.rec);
   assign mem_waddr = clear_busy_ff ? clear_addr_ff : pop_data.addr;
   assign mem_wdata = clear_busy_ff ? '0 : pop_data.live;

   assign mix = {1'b0, s1_live_half_ff} + {1'b0, rd_data_ff[SAMPLE_W-1:1]};

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.mixed_sample     = out_mix_ff;
   assign rsp_chan.recording_active = out_rec_ff;

   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_LAST) begin
            clear_busy_in = 1'b0;
         end
      end
      s1_valid_in  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   // The read returns the old word when it meets a write to the same address.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         loop_store[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= loop_store[pop_data.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_live_half_ff <= pop_data.live[SAMPLE_W-1:1];
         s1_rec_ff       <= pop_data.rec;
      end
      if (s1_adv) begin
         out_mix_ff <= mix;
         out_rec_ff <= s1_rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   a_clear_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (!s1_valid_ff && !out_valid_ff && !pop))
      else $error("pipeline active during the store clearing pass");

   a_clear_ends_at_last: assert property (@(posedge clock) disable iff (reset)
      (clear_busy_ff && !clear_busy_in) |-> (clear_addr_ff == ADDR_LAST))
      else $error("store clearing pass ended early");

endmodule

// ===== design/audio_loop_recorder_mixer_unit.sv =====
// Top level of the audio loop recorder and mixer.
// A sample word's response is valid once the word has passed the queue, stage one and the output register.
// Throughput is one word per cycle while the response side does not stall.
// A click word gives no response word.
// After reset the loop store is cleared address by address with req ready held low.
module audio_loop_recorder_mixer_unit (
   input  logic       clock,
   input  logic       reset,
   alrm_req_if.sink   req_chan,
   alrm_rsp_if.source rsp_chan
);
   import alrm_pkg::*;

   logic        push_valid;
   logic        push_ready;
   loop_op_type push_data;
   logic        pop_valid;
   logic        pop_ready;
   loop_op_type pop_data;
   logic        clear_busy;

   alrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   alrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   alrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the audio loop recorder and mixer.
`timescale 1ns / 100ps

module tb;
   import alrm_pkg::*;

   localparam int CYCLE_LIMIT   = 1500000;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_WORDS  = 600;
   localparam int MAX_WAIT      = 18;
   localparam int REPORT_LIMIT  = 10;
   localparam logic TYPED       = 1'b1;
   localparam logic PREDICTED   = 1'b0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mix;
      logic                rec;
   } mix_word_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [WORD_W-1:0] word;
      logic              typed;
      mix_word_type      res;
   } script_row_type;

   localparam mix_word_type NO_WORD = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   alrm_req_if req_chan();
   alrm_rsp_if rsp_chan();

   audio_loop_recorder_mixer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bit [SAMPLE_W-1:0] model_loop [LOOP_DEPTH];
   logic [LEN_W-1:0]   model_pos    = '0;
   logic [LEN_W-1:0]   model_len    = LEN_RESET;
   logic [COUNT_W-1:0] model_clicks = '0;
   logic               model_rec    = 1'b0;

   mix_word_type mixed_due[$];
   mix_word_type got_word;
   mix_word_type due_word;
   int           mismatches  = 0;
   int           stall_left  = 0;
   int           cycle_count = 0;
   bit           no_idle     = 1'b0;

   script_row_type script [DIRECTED_ROWS] = '{
      '{REQ_SAMPLE, 32'h0000_0000, TYPED,     '{16'h0000, 1'b0}},
      '{REQ_SAMPLE, 32'hFFFF_FFFF, TYPED,     '{16'h7FFF, 1'b0}},
      '{REQ_SAMPLE, 32'h0003_FFFC, TYPED,     '{16'h7FFF, 1'b0}},
      '{REQ_SAMPLE, 32'hFFFC_0003, TYPED,     '{16'h0000, 1'b0}},
      '{REQ_SAMPLE, 32'h0000_0004, TYPED,     '{16'h0000, 1'b0}},
      '{REQ_SAMPLE, 32'h0000_0008, TYPED,     '{16'h0001, 1'b0}},
      '{REQ_SAMPLE, 32'h0002_0000, TYPED,     '{16'h4000, 1'b0}},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h0003_FFFC, TYPED,     '{16'h7FFF, 1'b1}},
      '{REQ_SAMPLE, 32'hFFFF_FFFF, TYPED,     '{16'h7FFF, 1'b1}},
      '{REQ_SAMPLE, 32'h1234_5678, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h8765_4321, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h0001_5554, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h5A5A_A5A5, PREDICTED, NO_WORD},
      '{REQ_CLICK,  32'hFFFF_FFFF, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'hFFFF_FFFF, TYPED,     '{16'hFFFE, 1'b0}},
      '{REQ_SAMPLE, 32'h0000_0000, TYPED,     '{16'h7FFF, 1'b0}},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'h0003_FFFC, PREDICTED, NO_WORD},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_CLICK,  32'h0000_0000, PREDICTED, NO_WORD},
      '{REQ_SAMPLE, 32'hFFFF_FFFF, PREDICTED, NO_WORD}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic bit step_loop(input req_kind_type kind, input logic [WORD_W-1:0] word,
                                    output mix_word_type res);
      logic [SAMPLE_W-1:0] live;
      logic [SAMPLE_W-1:0] stored;
      res = '0;
      if (kind == REQ_CLICK) begin
         if (model_clicks != CLICK_MAX) model_clicks = model_clicks + COUNT_W'(1);
         model_rec = ~model_rec;
         return 1'b0;
      end
      if (model_clicks == CLICK_RESTART) begin
         model_pos    = '0;
         model_clicks = CLICK_RESTARTED;
      end
      if (model_clicks == CLICK_FIX_LEN) begin
         model_len    = model_pos;
         model_clicks = CLICK_LEN_FIXED;
      end
      if (model_pos >= LEN_RESET) model_pos = '0;
      live    = word[LIVE_LSB +: SAMPLE_W];
      stored  = model_loop[model_pos[ADDR_W-1:0]];
      res.mix = (live >> 1) + (stored >> 1);
      res.rec = model_rec;
      if (model_rec) model_loop[model_pos[ADDR_W-1:0]] = live;
      model_pos = model_pos + LEN_W'(1);
      if (model_pos >= model_len) model_pos = '0;
      return 1'b1;
   endfunction

   task automatic send_word(input req_kind_type kind, input logic [WORD_W-1:0] word,
                            input logic typed, input mix_word_type typed_res);
      int           gap;
      mix_word_type res;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.sample_word <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (step_loop(kind, word, res)) mixed_due.push_back(typed ? typed_res : res);
   endtask

   task automatic flag_mismatch(input string what, input mix_word_type due,
                                input mix_word_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s: expected mix %h rec %b, got mix %h rec %b",
                  what, due.mix, due.rec, got.mix, got.rec);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         got_word.mix = rsp_chan.mixed_sample;
         got_word.rec = rsp_chan.recording_active;
         if (mixed_due.size() == 0) begin
            flag_mismatch("unexpected word", NO_WORD, got_word);
         end else begin
            due_word = mixed_due.pop_front();
            if (got_word.mix !== due_word.mix || got_word.rec !== due_word.rec)
               flag_mismatch("mismatch", due_word, got_word);
         end
         stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_chan.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= (stall_left == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                row;
      int                n;
      req_kind_type      kind;
      logic [WORD_W-1:0] word;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_SAMPLE;
      req_chan.sample_word = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++)
         send_word(script[row].kind, script[row].word, script[row].typed, script[row].res);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
         if (n == RANDOM_WORDS / 2) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (mixed_due.size() != 0);
         end
         kind = ($urandom_range(0, 7) == 0) ? REQ_CLICK : REQ_SAMPLE;
         case ($urandom_range(0, 7))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
         endcase
         send_word(kind, word, PREDICTED, NO_WORD);
      end
      req_chan.valid <= 1'b0;

      while (mixed_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && mixed_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
